// ===== rtl/pafb_pkg.sv =====
`timescale 1ns / 1ps
package pafb_pkg;

  // Fixed geometry of the filterbank.
  localparam int WINDOW_TAPS  = 512;
  localparam int NUM_SUBBANDS = 32;
  localparam int DEF_NUM_CHANNELS = 2;

  // Datapath widths: samples Q15, window Q2.22, cosine Q2.16.
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 19;
  localparam int YW       = 38;
  localparam int PROD_W   = YW + COEF_W;
  localparam int ACC_W    = 64;
  localparam int OUT_W    = 24;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic op_valid;
    logic acc_clear;
  } mac_ctrl_t;

  // First half of the analysis window, C[0..256], in units of 2^-21.
  localparam logic signed [17:0] WIN_HALF [257] = '{
    0, -1, -1, -1, -1, -1, -1, -2, -2, -2,
    -2, -3, -3, -4, -4, -5, -5, -6, -7, -7,
    -8, -9, -10, -11, -13, -14, -16, -17, -19, -21,
    -24, -26, -29, -31, -35, -38, -41, -45, -49, -53,
    -58, -63, -68, -73, -79, -85, -91, -97, -104, -111,
    -117, -125, -132, -139, -147, -154, -161, -169, -176, -183,
    -190, -196, -202, -208, 213, 218, 222, 225, 227, 228,
    228, 227, 224, 221, 215, 208, 200, 189, 177, 163,
    146, 127, 106, 83, 57, 29, -2, -36, -72, -111,
    -153, -197, -244, -294, -347, -401, -459, -519, -581, -645,
    -711, -779, -848, -919, -991, -1064, -1137, -1210, -1283, -1356,
    -1428, -1498, -1567, -1634, -1698, -1759, -1817, -1870, -1919, -1962,
    -2001, -2032, -2057, -2075, -2085, -2087, -2080, -2063, 2037, 2000,
    1952, 1893, 1822, 1739, 1644, 1535, 1414, 1280, 1131, 970,
    794, 605, 402, 185, -45, -288, -545, -814, -1095, -1388,
    -1692, -2006, -2330, -2663, -3004, -3351, -3705, -4063, -4425, -4788,
    -5153, -5517, -5879, -6237, -6589, -6935, -7271, -7597, -7910, -8209,
    -8491, -8755, -8998, -9219, -9416, -9585, -9727, -9838, -9916, -9959,
    -9966, -9935, -9863, -9750, -9592, -9389, -9139, -8840, -8492, -8092,
    -7640, -7134, 6574, 5959, 5288, 4561, 3776, 2935, 2037, 1082,
    70, -998, -2122, -3300, -4533, -5818, -7154, -8540, -9975, -11455,
    -12980, -14548, -16155, -17799, -19478, -21189, -22929, -24694, -26482, -28289,
    -30112, -31947, -33791, -35640, -37489, -39336, -41176, -43006, -44821, -46617,
    -48390, -50137, -51853, -53534, -55178, -56778, -58333, -59838, -61289, -62684,
    -64019, -65290, -66494, -67629, -68692, -69679, -70590, -71420, -72169, -72835,
    -73415, -73908, -74313, -74630, -74856, -74992, 75038
  };

  // cos(n*pi/64) in Q2.16 for n = 0..32.
  localparam logic [16:0] COS_Q [33] = '{
    65536, 65457, 65220, 64827, 64277, 63572, 62714, 61705, 60547, 59244,
    57798, 56212, 54491, 52639, 50660, 48559, 46341, 44011, 41576, 39040,
    36410, 33692, 30893, 28020, 25080, 22078, 19024, 15924, 12785, 9616,
    6424, 3216, 0
  };

  // Window tap t in Q2.22; the second half mirrors the first.
  function automatic logic signed [COEF_W-1:0] window_tap(input logic [8:0] t);
    logic [8:0] k;
    logic signed [COEF_W-1:0] v;
    if (t <= 9'd256) begin
      return {WIN_HALF[t], 1'b0};
    end
    k = 9'(10'd512 - {1'b0, t});
    v = {WIN_HALF[k], 1'b0};
    return (k[5:0] == 6'd0) ? v : -v;
  endfunction

  // cos(n*pi/64) in Q2.16 for any n modulo 128.
  function automatic logic signed [COEF_W-1:0] cos_entry(input logic [6:0] n);
    logic [7:0] r;
    logic neg;
    logic signed [COEF_W-1:0] v;
    r = {1'b0, n};
    neg = 1'b0;
    if (r > 8'd64) begin
      r = 8'(9'd128 - {1'b0, r});
    end
    if (r > 8'd32) begin
      r = 8'(8'd64 - r);
      neg = 1'b1;
    end
    v = {2'b00, COS_Q[r[5:0]]};
    return neg ? -v : v;
  endfunction

endpackage

// ===== rtl/polyphase_analysis_filterbank.sv =====
`timescale 1ns / 1ps
// 32-subband polyphase analysis filterbank. Each input request carries one 16-bit PCM
// sample for a channel; on every 32nd sample of a channel the block runs the window
// (64 sums of 8 taps) and the 32x64 cosine matrix on one shared multiply-accumulate
// unit and sends 32 saturated Q3.21 subband samples, the last one flagged. A sample
// that starts no analysis is only written to the history. An analysis takes as long as
// the single MAC and its one-read history and partial-sum memories need, plus the time
// the consumer needs per result; the input is not ready meanwhile. After reset a
// clearing pass zeroes the history of all NUM_CHANNELS channels.
module polyphase_analysis_filterbank import pafb_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] pcm_sample
  input  logic        s_axis_tuser,  // [0] channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [4:0] subband_index, [28:5] subband_value, zero fill
  output logic        m_axis_tuser,  // [0] out_channel
  output logic        m_axis_tlast   // last_of_block
);

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW    = CH_W + 9;
  localparam int DEPTH = NUM_CHANNELS * WINDOW_TAPS;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_WIN    = 7'b0000100,
    ST_WDRAIN = 7'b0001000,
    ST_MAT    = 7'b0010000,
    ST_MDRAIN = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [8:0]      rp_q   [NUM_CHANNELS];
  logic [4:0]      fill_q [NUM_CHANNELS];
  logic [8:0]      ana_rp_q;
  logic [CH_W-1:0] ana_ch_q;
  logic [5:0]      idx_q, idx_d;
  logic [5:0]      term_q, term_d;

  logic                      rd_v_q, rd_v_d;
  logic                      rd_mat_q, rd_mat_d;
  logic signed [COEF_W-1:0]  coef_q, coef_d;

  logic signed [SAMPLE_W-1:0] hist_mem [DEPTH];
  logic signed [SAMPLE_W-1:0] hist_rd_q;
  logic signed [YW-1:0]       y_mem [64];
  logic signed [YW-1:0]       y_rd_q;

  logic [CH_W-1:0] ch_idx;
  logic            ch_ok, in_acc;
  logic [4:0]      fill_nxt;
  logic            hist_we;
  logic [AW-1:0]   hist_waddr, hist_raddr;
  logic signed [SAMPLE_W-1:0] hist_wdata;
  logic [8:0]      win_t, win_slot;
  logic [12:0]     mat_prod;
  logic [6:0]      mat_n;
  logic            drained, y_we;

  mac_ctrl_t               mac_ctrl;
  logic                    mac_clear;
  logic signed [YW-1:0]    mac_a;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_busy;

  logic [4:0]              out_idx_q;
  logic signed [OUT_W-1:0] out_val_q, out_val_d;
  logic                    out_ch_q;

  // Input request decode.
  assign ch_idx        = CH_W'(s_axis_tuser);
  assign ch_ok         = (32'(ch_idx) < NUM_CHANNELS);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready && ch_ok;
  assign fill_nxt      = fill_q[ch_idx] + 5'd1;

  // Per-channel ring position and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        rp_q[c]   <= '0;
        fill_q[c] <= '0;
      end
    end else if (in_acc) begin
      rp_q[ch_idx]   <= rp_q[ch_idx] + 9'd1;
      fill_q[ch_idx] <= fill_nxt;
    end
  end

  // Channel and ring position seen by the analysis.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ana_rp_q <= rp_q[ch_idx] + 9'd1;
      ana_ch_q <= ch_idx;
    end
  end

  // History memory: clearing pass or sample write, one windowed read.
  assign hist_we    = (state_q == ST_CLEAR) || in_acc;
  assign hist_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : {ch_idx, rp_q[ch_idx]};
  assign hist_wdata = (state_q == ST_CLEAR) ? '0 : signed'(s_axis_tdata);
  assign win_t      = {term_q[2:0], idx_q};
  assign win_slot   = ana_rp_q - 9'd1 - win_t;
  assign hist_raddr = {ana_ch_q, win_slot};

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd_q <= hist_mem[hist_raddr];
  end

  // Partial-sum memory, 64 window sums.
  always_ff @(posedge clk_i) begin
    if (y_we) begin
      y_mem[idx_q] <= acc[YW-1:0];
    end
    y_rd_q <= y_mem[term_q];
  end

  // Cosine index ((2i+1)*(m-16)) modulo 128.
  assign mat_prod = {idx_q[4:0], 1'b1} * 7'(term_q + 6'd48 + 7'd64);
  assign mat_n    = mat_prod[6:0];

  // Shared MAC operands, aligned with the registered memory reads.
  assign mac_a    = rd_mat_q ? y_rd_q : YW'(hist_rd_q);
  assign mac_ctrl = '{op_valid: rd_v_q, acc_clear: mac_clear};
  assign drained  = !rd_v_q && !mac_busy;

  pafb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (coef_q),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  // Round the Q53 sum to Q3.21, ties away from zero, and saturate.
  always_comb begin
    logic        neg;
    logic [63:0] mag;
    logic [31:0] r;
    neg = acc[ACC_W-1];
    mag = neg ? 64'(-acc) : 64'(acc);
    r   = 32'((mag + 64'h8000_0000) >> 32);
    if (!neg) begin
      out_val_d = (r > 32'd8388607) ? 24'sh7FFFFF : signed'(r[23:0]);
    end else begin
      out_val_d = (r > 32'd8388608) ? 24'sh800000 : signed'(24'(-r[23:0]));
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    idx_d     = idx_q;
    term_d    = term_q;
    rd_v_d    = 1'b0;
    rd_mat_d  = rd_mat_q;
    coef_d    = coef_q;
    y_we      = 1'b0;
    mac_clear = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && fill_nxt == 5'd0) begin
          state_d = ST_WIN;
          idx_d   = '0;
          term_d  = '0;
        end
      end
      ST_WIN: begin
        rd_v_d   = 1'b1;
        rd_mat_d = 1'b0;
        coef_d   = window_tap(win_t);
        term_d   = term_q + 6'd1;
        if (term_q[2:0] == 3'd7) begin
          term_d  = '0;
          state_d = ST_WDRAIN;
        end
      end
      ST_WDRAIN: begin
        if (drained) begin
          y_we      = 1'b1;
          mac_clear = 1'b1;
          idx_d     = idx_q + 6'd1;
          state_d   = (idx_q == 6'd63) ? ST_MAT : ST_WIN;
        end
      end
      ST_MAT: begin
        rd_v_d   = 1'b1;
        rd_mat_d = 1'b1;
        coef_d   = cos_entry(mat_n);
        term_d   = term_q + 6'd1;
        if (term_q == 6'd63) begin
          state_d = ST_MDRAIN;
        end
      end
      ST_MDRAIN: begin
        if (drained) begin
          mac_clear = 1'b1;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_axis_tready) begin
          if (idx_q[4:0] == 5'd31) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 6'd1;
            term_d  = '0;
            state_d = ST_MAT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      idx_q     <= '0;
      term_q    <= '0;
      rd_v_q    <= 1'b0;
      rd_mat_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      idx_q     <= idx_d;
      term_q    <= term_d;
      rd_v_q    <= rd_v_d;
      rd_mat_q  <= rd_mat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  // Output register, loaded when a subband sum is complete.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MDRAIN && drained) begin
      out_val_q <= out_val_d;
      out_idx_q <= idx_q[4:0];
      out_ch_q  <= ana_ch_q[0];
    end
  end

  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tdata  = {3'b000, out_val_q, out_idx_q};
  assign m_axis_tuser  = out_ch_q;
  assign m_axis_tlast  = (out_idx_q == 5'd31);

`ifndef SYNTH
  // No input is taken while a result is offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is pending");

  // The 32nd sample of a channel starts the window pass.
  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fill_nxt == 5'd0) |=> (state_q == ST_WIN))
    else $error("analysis did not start");

  // The MAC pipeline is empty whenever a sum is written or emitted.
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (y_we || m_axis_tvalid) |-> (!rd_v_q && !mac_busy))
    else $error("sum taken before the MAC drained");
`endif

endmodule

// ===== rtl/pafb_mac.sv =====
`timescale 1ns / 1ps
module pafb_mac import pafb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [YW-1:0]     a_i,
  input  logic signed [COEF_W-1:0] b_i,
  output logic signed [ACC_W-1:0]  acc_o,
  output logic                     busy_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_v_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  // Product register between the multiplier and the adder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.op_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op_valid) begin
      prod_q <= a_i * b_i;
    end
  end

  // Accumulator.
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_v_q;

endmodule
